>>> rtl/srs_pkg.sv
// ----------------------------------------------------------------------------
// srs_pkg
// Shared types and constants for the streaming substring replace block.
// ----------------------------------------------------------------------------
package srs_pkg;

  // configuration register indexes
  localparam logic [2:0] RegPattern     = 3'd0;
  localparam logic [2:0] RegPatternLen  = 3'd1;
  localparam logic [2:0] RegRepl        = 3'd2;
  localparam logic [2:0] RegReplLen     = 3'd3;
  localparam logic [2:0] RegStartOcc    = 3'd4;
  localparam logic [2:0] RegChangeLimit = 3'd5;
  localparam logic [2:0] RegIgnoreCase  = 3'd6;

  // results one item may cause, and the queue between front and back
  localparam int MaxResults = 8;
  localparam int ResIdxW    = 3;
  localparam int QueueDepth = 4;
  localparam int QPtrW      = 2;
  localparam int QCntW      = 3;

  // live configuration
  typedef struct packed {
    logic [63:0] pattern;
    logic [3:0]  pat_len;
    logic [63:0] repl;
    logic [3:0]  repl_len;
    logic [15:0] start_occ;
    logic [15:0] change_limit;
    logic        ignore_case;
  } cfg_t;

  // one queued burst: head bytes, then the flushed window, then end flag
  typedef struct packed {
    logic [7:0][7:0] head;
    logic [3:0]      head_cnt;
    logic [7:0][7:0] tail;
    logic [3:0]      tail_cnt;
    logic            last;
  } q_entry_t;

  // ascii upper-casing when case is ignored
  function automatic logic [7:0] fold(input logic [7:0] c, input logic ic);
    logic [7:0] r;
    r = c;
    if (ic && c >= 8'h61 && c <= 8'h7a) r = c - 8'h20;
    return r;
  endfunction

endpackage

>>> rtl/srs_front.sv
// ----------------------------------------------------------------------------
// srs_front
// Takes source bytes, keeps the match window and per-string counters, and
// turns each item that yields results or ends a string into one queued burst.
// ----------------------------------------------------------------------------
module srs_front import srs_pkg::*; #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cfg_t     cfg_i,
  input  logic     accept_i,
  input  logic [7:0] src_byte_i,
  input  logic     present_i,
  input  logic     last_i,
  output logic     push_o,
  output q_entry_t entry_o
);

  localparam int CntW = $clog2(MAX_PATTERN + 1);
  localparam int IdxW = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

  logic                              in_string_q;
  logic [CntW-1:0]                   al_q;
  logic [15:0]                       skips_q, changes_q;
  logic                              pt_q;
  logic [CntW-1:0]                   wc_q;
  logic [MAX_PATTERN-1:0][7:0]       win_q;

  logic [CntW-1:0]                   al, wc;
  logic [15:0]                       skips, changes;
  logic                              pt, match;
  logic [MAX_PATTERN-1:0][7:0]       win;
  logic [7:0][7:0]                   hbytes, tbytes;
  logic [3:0]                        hc;
  logic [3:0]                        pat_clamp, repl_clamp;

  assign pat_clamp  = (cfg_i.pat_len > 4'(MAX_PATTERN)) ? 4'(MAX_PATTERN) : cfg_i.pat_len;
  assign repl_clamp = (cfg_i.repl_len > 4'(MAX_REPLACEMENT)) ? 4'(MAX_REPLACEMENT)
                                                              : cfg_i.repl_len;

  // per-item window update and burst composition
  always_comb begin
    al      = in_string_q ? al_q : CntW'(pat_clamp);
    skips   = in_string_q ? skips_q
                          : ((cfg_i.start_occ == 16'd0) ? 16'd0 : cfg_i.start_occ - 16'd1);
    changes = in_string_q ? changes_q : cfg_i.change_limit;
    pt      = in_string_q ? pt_q : 1'b0;
    wc      = in_string_q ? wc_q : '0;
    win     = win_q;
    hbytes  = '0;
    hc      = '0;
    match   = 1'b1;
    if (present_i) begin
      if (pt || al == '0) begin
        hbytes[0] = src_byte_i;
        hc        = 4'd1;
      end else begin
        if (wc >= al) wc = '0;
        win[wc[IdxW-1:0]] = src_byte_i;
        wc = wc + 1'b1;
        if (wc == al) begin
          for (int i = 0; i < MAX_PATTERN; i++) begin
            if (CntW'(i) < al &&
                fold(win[i], cfg_i.ignore_case) !=
                fold(cfg_i.pattern[8*i +: 8], cfg_i.ignore_case)) match = 1'b0;
          end
          if (!match || skips != 16'd0) begin
            // release one byte and slide the window
            if (match) skips = skips - 16'd1;
            hbytes[0] = win[0];
            hc        = 4'd1;
            for (int i = 0; i < MAX_PATTERN - 1; i++) win[i] = win[i+1];
            wc = wc - 1'b1;
          end else begin
            // replace the whole occurrence
            hbytes = cfg_i.repl;
            hc     = repl_clamp;
            wc     = '0;
            if (changes != 16'd0) begin
              changes = changes - 16'd1;
              if (changes == 16'd0) pt = 1'b1;
            end
          end
        end
      end
    end
    tbytes = '0;
    for (int i = 0; i < MAX_PATTERN && i < 8; i++) tbytes[i] = win[i];
  end

  assign entry_o.head     = hbytes;
  assign entry_o.head_cnt = hc;
  assign entry_o.tail     = tbytes;
  assign entry_o.tail_cnt = last_i ? 4'(wc) : 4'd0;
  assign entry_o.last     = last_i;
  assign push_o           = accept_i && (hc != 4'd0 || last_i);

  // string state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_string_q <= 1'b0;
      al_q        <= '0;
      skips_q     <= '0;
      changes_q   <= '0;
      pt_q        <= 1'b0;
      wc_q        <= '0;
    end else if (accept_i) begin
      in_string_q <= !last_i;
      al_q        <= al;
      skips_q     <= skips;
      changes_q   <= changes;
      pt_q        <= pt;
      wc_q        <= last_i ? '0 : wc;
    end
  end

  // window bytes
  always_ff @(posedge clk_i) begin
    if (accept_i) win_q <= win;
  end

  a_last_clears : assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i && last_i |=> wc_q == '0 && !in_string_q)
    else $error("window not flushed at end of string");

endmodule

>>> rtl/srs_queue.sv
// ----------------------------------------------------------------------------
// srs_queue
// Short first-in first-out queue of bursts between front and back.
// ----------------------------------------------------------------------------
module srs_queue import srs_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     push_i,
  input  q_entry_t entry_i,
  input  logic     pop_i,
  output q_entry_t head_o,
  output logic     empty_o,
  output logic     full_o
);

  q_entry_t               mem_q [QueueDepth];
  logic [QPtrW-1:0]       wr_q, rd_q;
  logic [QCntW-1:0]       cnt_q;

  assign empty_o = (cnt_q == '0);
  assign full_o  = (cnt_q == QCntW'(QueueDepth));
  assign head_o  = mem_q[rd_q];

  // pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (pop_i)  rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + QCntW'(push_i) - QCntW'(pop_i);
    end
  end

  // storage
  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= entry_i;
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !full_o || pop_i)
    else $error("queue overflow");

  a_level_bound : assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= QCntW'(QueueDepth))
    else $error("queue level out of range");

endmodule

>>> rtl/srs_back.sv
// ----------------------------------------------------------------------------
// srs_back
// Walks through each queued burst and presents one result per cycle, while
// the receiver is ready, from a registered output stage.
// ----------------------------------------------------------------------------
module srs_back import srs_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  q_entry_t   entry_i,
  input  logic       empty_i,
  output logic       pop_o,
  output logic       m_tvalid_o,
  input  logic       m_tready_i,
  output logic [7:0] m_tdata_o,
  output logic       m_tuser_o,
  output logic       m_tlast_o
);

  logic [ResIdxW-1:0] idx_q, last_idx;
  logic               valid_q, user_q, tlast_q;
  logic [7:0]         data_q, item_byte;
  logic [4:0]         sum;
  logic [3:0]         n_items;
  logic               take;

  // number of results in the current burst, one for an empty end marker
  assign sum      = {1'b0, entry_i.head_cnt} + {1'b0, entry_i.tail_cnt};
  assign n_items  = (sum == 5'd0) ? 4'd1
                  : ((sum > 5'(MaxResults)) ? 4'(MaxResults) : sum[3:0]);
  assign last_idx = ResIdxW'(n_items - 4'd1);
  assign take     = !empty_i && (!valid_q || m_tready_i);
  assign pop_o    = take && (idx_q == last_idx);

  // select head byte or flushed window byte
  always_comb begin
    if ({1'b0, idx_q} < entry_i.head_cnt) item_byte = entry_i.head[idx_q];
    else item_byte = entry_i.tail[idx_q - entry_i.head_cnt[ResIdxW-1:0]];
  end

  // output valid and burst position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (!valid_q || m_tready_i) begin
      valid_q <= !empty_i;
      if (!empty_i) idx_q <= (idx_q == last_idx) ? '0 : idx_q + 1'b1;
    end
  end

  // output payload, a bare end marker carries a zero byte
  always_ff @(posedge clk_i) begin
    if (take) begin
      data_q  <= (sum == 5'd0) ? 8'h00 : item_byte;
      user_q  <= (sum != 5'd0);
      tlast_q <= entry_i.last && (idx_q == last_idx);
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = data_q;
  assign m_tuser_o  = user_q;
  assign m_tlast_o  = tlast_q;

  a_pop_nonempty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |-> !empty_i)
    else $error("pop from empty queue");

  a_idx_idle : assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_i |-> idx_q == '0)
    else $error("burst position left over with empty queue");

endmodule

>>> rtl/substring_replace_stream_top.sv
// ----------------------------------------------------------------------------
// substring_replace_stream_top
// Streaming find-and-replace of a configured byte pattern.
//
// Source bytes come in on the s_ channel, results leave on the m_ channel.
// s_tuser_i flags that s_tdata_i carries a byte, s_tlast_i ends a string.
// m_tuser_o flags that m_tdata_o carries a byte, m_tlast_o marks the final
// result of a string (an empty string yields one result without a byte).
// Registers are to be written through the cfg_ channel between strings; the
// block does not enforce it. Results pass the burst queue and a registered
// output stage. One item is taken per cycle while each item yields at most
// one result and the receiver is ready; an item with more results holds the
// output stage while a four-entry burst queue lets the input run ahead.
// When the receiver stalls, the output stage holds and the queue fills, then
// s_tready_o drops. Reset empties the queue and the window, clears the string
// state and restores register defaults (start occurrence one).
// ----------------------------------------------------------------------------
module substring_replace_stream_top import srs_pkg::*; #(
  parameter int MAX_PATTERN     = 8,
  parameter int MAX_REPLACEMENT = 8
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [7:0]  s_tdata_i,   // source_byte
  input  logic        s_tuser_i,   // byte_present
  input  logic        s_tlast_i,   // end_of_source
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [7:0]  m_tdata_o,   // out_byte
  output logic        m_tuser_o,   // out_valid
  output logic        m_tlast_o,   // out_last
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i
);

  cfg_t     cfg_q;
  q_entry_t f_entry, q_head;
  logic     s_accept, push, pop, q_empty, q_full;

  assign cfg_ready_o = 1'b1;
  assign s_tready_o  = !q_full;
  assign s_accept    = s_tvalid_i && s_tready_o;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pattern      <= '0;
      cfg_q.pat_len      <= '0;
      cfg_q.repl         <= '0;
      cfg_q.repl_len     <= '0;
      cfg_q.start_occ    <= 16'd1;
      cfg_q.change_limit <= '0;
      cfg_q.ignore_case  <= 1'b0;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegPattern:     cfg_q.pattern      <= cfg_data_i;
        RegPatternLen:  cfg_q.pat_len      <= cfg_data_i[3:0];
        RegRepl:        cfg_q.repl         <= cfg_data_i;
        RegReplLen:     cfg_q.repl_len     <= cfg_data_i[3:0];
        RegStartOcc:    cfg_q.start_occ    <= cfg_data_i[15:0];
        RegChangeLimit: cfg_q.change_limit <= cfg_data_i[15:0];
        RegIgnoreCase:  cfg_q.ignore_case  <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  srs_front #(
    .MAX_PATTERN     (MAX_PATTERN),
    .MAX_REPLACEMENT (MAX_REPLACEMENT)
  ) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_i      (cfg_q),
    .accept_i   (s_accept),
    .src_byte_i (s_tdata_i),
    .present_i  (s_tuser_i),
    .last_i     (s_tlast_i),
    .push_o     (push),
    .entry_o    (f_entry)
  );

  srs_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (f_entry),
    .pop_i   (pop),
    .head_o  (q_head),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  srs_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .entry_i    (q_head),
    .empty_i    (q_empty),
    .pop_o      (pop),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o),
    .m_tuser_o  (m_tuser_o),
    .m_tlast_o  (m_tlast_o)
  );

endmodule

>>> verif/srs_replace_check.sv
// ----------------------------------------------------------------------------
// srs_replace_check
// Watches the source, result and register channels of the substring replace
// block. Keeps its own copy of the registers and of the match window, works
// out the bytes each accepted source transaction must produce and compares
// every accepted result transaction against the oldest one still due.
// ----------------------------------------------------------------------------
module srs_replace_check import srs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [7:0]  s_tdata_i,   // source_byte
  input  logic        s_tuser_i,   // byte_present
  input  logic        s_tlast_i,   // end_of_source
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [7:0]  m_tdata_i,   // out_byte
  input  logic        m_tuser_i,   // out_valid
  input  logic        m_tlast_i,   // out_last
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [2:0]  cfg_index_i,
  input  logic [63:0] cfg_data_i,
  output int          fail_count_o,
  output int          pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int MaxPattern = 8;
  localparam int MaxRepl    = 8;

  typedef struct packed {
    logic [7:0] data;
    logic       has_byte;
    logic       last;
  } out_item_t;

  // register copy and string state
  cfg_t        regs;
  logic [7:0]  win [MaxPattern];
  logic [3:0]  win_cnt;
  logic [3:0]  active_len;
  logic [15:0] skips_left;
  logic [15:0] changes_left;
  logic        pass_thru;
  logic        in_string;

  out_item_t   step_out[$];
  out_item_t   out_bytes_due[$];
  out_item_t   want;
  int          fail_count;

  // ascii letters upper-cased when case is ignored
  function automatic logic [7:0] case_fold(input logic [7:0] c);
    if (regs.ignore_case && c >= 8'h61 && c <= 8'h7a) return c - 8'h20;
    return c;
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    if (step_out.size() < MaxResults) step_out.push_back('{b, 1'b1, 1'b0});
  endfunction

  function automatic bit window_hit();
    for (int i = 0; i < active_len && i < MaxPattern; i++) begin
      if (case_fold(win[i]) != case_fold(regs.pattern[8*i +: 8])) return 1'b0;
    end
    return 1'b1;
  endfunction

  // send the oldest window byte and shift the rest down
  function automatic void release_front();
    emit_byte(win[0]);
    for (int i = 1; i < win_cnt && i < MaxPattern; i++) win[i-1] = win[i];
    if (win_cnt > 0) win_cnt--;
  endfunction

  // bytes one source transaction produces, appended to the due list
  function automatic void predict_replace(input logic [7:0] b, input logic present,
                                          input logic last);
    int rl;
    step_out.delete();

    // string start latches length and counters
    if (!in_string) begin
      active_len   = (regs.pat_len > MaxPattern) ? 4'(MaxPattern) : regs.pat_len;
      skips_left   = (regs.start_occ == 16'd0) ? 16'd0 : regs.start_occ - 16'd1;
      changes_left = regs.change_limit;
      pass_thru    = 1'b0;
      win_cnt      = '0;
      in_string    = 1'b1;
    end

    if (present) begin
      if (pass_thru || active_len == 0) begin
        emit_byte(b);
      end else begin
        if (win_cnt >= active_len) win_cnt = '0;
        win[win_cnt] = b;
        win_cnt++;
        if (win_cnt == active_len) begin
          if (!window_hit()) begin
            release_front();
          end else if (skips_left > 0) begin
            // skipped occurrence: search goes on overlapping
            skips_left--;
            release_front();
          end else begin
            rl = (regs.repl_len > MaxRepl) ? MaxRepl : int'(regs.repl_len);
            for (int i = 0; i < rl; i++) emit_byte(regs.repl[8*i +: 8]);
            win_cnt = '0;
            if (changes_left > 0) begin
              changes_left--;
              if (changes_left == 0) pass_thru = 1'b1;
            end
          end
        end
      end
    end

    // end of string flushes the window, an empty one gives a bare end
    if (last) begin
      for (int i = 0; i < win_cnt && i < MaxPattern; i++) emit_byte(win[i]);
      win_cnt = '0;
      if (step_out.size() == 0) step_out.push_back('{8'h00, 1'b0, 1'b0});
      step_out[step_out.size()-1].last = 1'b1;
      in_string = 1'b0;
    end

    foreach (step_out[i]) out_bytes_due.push_back(step_out[i]);
  endfunction

  always @(posedge clk_i) begin
    if (!rst_ni) begin
      regs           = '0;
      regs.start_occ = 16'd1;
      for (int i = 0; i < MaxPattern; i++) win[i] = 8'h00;
      win_cnt      = '0;
      active_len   = '0;
      skips_left   = '0;
      changes_left = '0;
      pass_thru    = 1'b0;
      in_string    = 1'b0;
      fail_count   = 0;
      out_bytes_due.delete();
    end else begin
      // result transaction against the oldest due byte
      if (m_tvalid_i && m_tready_i) begin
        if (out_bytes_due.size() == 0) begin
          $error("result with nothing due: out_byte %02h out_valid %0b out_last %0b",
                 m_tdata_i, m_tuser_i, m_tlast_i);
          fail_count++;
        end else begin
          want = out_bytes_due.pop_front();
          if (m_tdata_i !== want.data) begin
            $error("out_byte mismatch: expected %02h, got %02h", want.data, m_tdata_i);
            fail_count++;
          end
          if (m_tuser_i !== want.has_byte) begin
            $error("out_valid mismatch: expected %0b, got %0b", want.has_byte, m_tuser_i);
            fail_count++;
          end
          if (m_tlast_i !== want.last) begin
            $error("out_last mismatch: expected %0b, got %0b", want.last, m_tlast_i);
            fail_count++;
          end
        end
      end

      // register write
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          RegPattern:     regs.pattern      = cfg_data_i;
          RegPatternLen:  regs.pat_len      = cfg_data_i[3:0];
          RegRepl:        regs.repl         = cfg_data_i;
          RegReplLen:     regs.repl_len     = cfg_data_i[3:0];
          RegStartOcc:    regs.start_occ    = cfg_data_i[15:0];
          RegChangeLimit: regs.change_limit = cfg_data_i[15:0];
          RegIgnoreCase:  regs.ignore_case  = cfg_data_i[0];
          default: ;
        endcase
      end

      // source transaction
      if (s_tvalid_i && s_tready_i) predict_replace(s_tdata_i, s_tuser_i, s_tlast_i);
    end
    pending_o    <= out_bytes_due.size();
    fail_count_o <= fail_count;
  end

endmodule

>>> verif/tb_substring_replace_stream_top.sv
// ----------------------------------------------------------------------------
// tb_substring_replace_stream_top
// Stimulus and verdict for the streaming substring replace block.
// A directed set of strings covers empty strings, bare end markers, case
// folding, skipped and overlapping occurrences, the change limit, deletion
// and oversized lengths; then random register settings with strings built
// mostly from the pattern. The source side sends in bursts with gaps, the
// result side stalls on its own pattern, and a separate check module
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_substring_replace_stream_top import srs_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IdleLimit   = 2000;
  localparam int RandomItems = 280;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        s_tvalid_i;
  logic        s_tready_o;
  logic [7:0]  s_tdata_i;    // source_byte
  logic        s_tuser_i;    // byte_present
  logic        s_tlast_i;    // end_of_source
  logic        m_tvalid_o;
  logic        m_tready_i;
  logic [7:0]  m_tdata_o;    // out_byte
  logic        m_tuser_o;    // out_valid
  logic        m_tlast_o;    // out_last
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i;
  logic [63:0] cfg_data_i;

  int fail_count;
  int pending_results;

  // current settings, used to build strings that hit the pattern
  logic [63:0] cur_pattern;
  logic [3:0]  cur_pat_len;
  logic        cur_ignore_case;

  int items_sent;
  int burst_left;
  bit gappy;
  int ready_mode;
  int ready_tick;
  int quiet_cycles;

  always #5 clk_i = ~clk_i;

  substring_replace_stream_top uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .s_tlast_i   (s_tlast_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o),
    .m_tlast_o   (m_tlast_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  srs_replace_check u_replace_check (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid_i),
    .s_tready_i   (s_tready_o),
    .s_tdata_i    (s_tdata_i),
    .s_tuser_i    (s_tuser_i),
    .s_tlast_i    (s_tlast_i),
    .m_tvalid_i   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_i    (m_tdata_o),
    .m_tuser_i    (m_tuser_o),
    .m_tlast_i    (m_tlast_o),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_i  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .fail_count_o (fail_count),
    .pending_o    (pending_results)
  );

  // receiver: ready pattern picked at random from four modes
  always @(negedge clk_i) begin
    if (ready_tick == 0) begin
      ready_mode = $urandom_range(0, 3);
      ready_tick = $urandom_range(20, 80);
    end else begin
      ready_tick--;
    end
    case (ready_mode)
      0: m_tready_i <= 1'b1;
      1: m_tready_i <= ($urandom_range(0, 3) != 0);
      2: m_tready_i <= ((ready_tick % 7) >= 2);
      default: m_tready_i <= ((ready_tick % 10) >= 6);
    endcase
  end

  task automatic idle_cycles(input int n);
    repeat (n) begin
      @(negedge clk_i);
      s_tvalid_i <= 1'b0;
    end
  endtask

  // one source transaction, with burst gaps in front of it
  task automatic send_item(input logic [7:0] b, input logic present, input logic last);
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 16);
      if (gappy) idle_cycles($urandom_range(1, 6));
    end
    burst_left--;
    @(negedge clk_i);
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= b;
    s_tuser_i  <= present;
    s_tlast_i  <= last;
    do @(posedge clk_i); while (!s_tready_o);
    if (present || last) items_sent++;
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [63:0] data);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
  endtask

  task automatic set_config(input logic [63:0] pat, input logic [3:0] plen,
                            input logic [63:0] repl, input logic [3:0] rlen,
                            input logic [15:0] start, input logic [15:0] limit,
                            input logic ic);
    write_reg(RegPattern, pat);
    write_reg(RegPatternLen, {60'd0, plen});
    write_reg(RegRepl, repl);
    write_reg(RegReplLen, {60'd0, rlen});
    write_reg(RegStartOcc, {48'd0, start});
    write_reg(RegChangeLimit, {48'd0, limit});
    write_reg(RegIgnoreCase, {63'd0, ic});
    @(negedge clk_i);
    cfg_valid_i     <= 1'b0;
    cur_pattern     = pat;
    cur_pat_len     = plen;
    cur_ignore_case = ic;
    gappy           = ($urandom_range(0, 2) != 0);
  endtask

  // wait for every due result, then let the block settle
  task automatic drain();
    idle_cycles(1);
    wait (pending_results == 0);
    repeat (12) @(negedge clk_i);
  endtask

  task automatic send_text(input string txt, input bit marker);
    for (int i = 0; i < txt.len(); i++) begin
      send_item(txt[i], 1'b1, (i == txt.len() - 1) && !marker);
    end
    if (marker) send_item(8'h00, 1'b0, 1'b1);
  endtask

  function automatic logic [7:0] pick_letter();
    case ($urandom_range(0, 4))
      0: return "a";
      1: return "b";
      2: return "A";
      3: return "B";
      default: return "c";
    endcase
  endfunction

  task automatic random_config();
    logic [63:0] pat;
    logic [3:0]  plen;
    logic [3:0]  rlen;
    logic [15:0] start;
    logic [15:0] limit;
    int          pick;
    pick = $urandom_range(0, 9);
    if (pick == 0)      plen = 4'd0;
    else if (pick <= 6) plen = 4'($urandom_range(1, 3));
    else if (pick == 7) plen = 4'($urandom_range(4, 8));
    else if (pick == 8) plen = 4'd8;
    else                plen = 4'($urandom_range(9, 15));
    for (int i = 0; i < 8; i++) begin
      pat[8*i +: 8] = ($urandom_range(0, 4) == 0) ? 8'($urandom_range(0, 255))
                                                  : pick_letter();
    end
    case ($urandom_range(0, 9))
      0: pat = '1;
      1: pat = '0;
      default: ;
    endcase
    rlen = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(9, 15))
                                       : 4'($urandom_range(0, 8));
    case ($urandom_range(0, 9))
      0, 1:    start = 16'd0;
      2, 3, 4: start = 16'd1;
      5, 6:    start = 16'd2;
      7, 8:    start = 16'd3;
      default: start = 16'hFFFF;
    endcase
    case ($urandom_range(0, 9))
      0, 1, 2: limit = 16'd0;
      3, 4:    limit = 16'd1;
      5, 6:    limit = 16'd2;
      7, 8:    limit = 16'd3;
      default: limit = 16'hFFFF;
    endcase
    set_config(pat, plen, {32'($urandom), 32'($urandom)}, rlen, start, limit,
               1'($urandom_range(0, 1)));
  endtask

  // string built mostly of pattern copies with noise between them
  task automatic send_random_string();
    int         len;
    int         eff_len;
    logic [7:0] b;
    eff_len = (cur_pat_len > 8) ? 8 : int'(cur_pat_len);
    len = $urandom_range(0, 14);
    for (int k = 0; k < len; k++) begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4: begin
          if (eff_len == 0) begin
            send_item(pick_letter(), 1'b1, 1'b0);
          end else begin
            // whole pattern, letters case-flipped now and then when case is ignored
            for (int i = 0; i < eff_len; i++) begin
              b = cur_pattern[8*i +: 8];
              if (cur_ignore_case && (b | 8'h20) >= 8'h61 && (b | 8'h20) <= 8'h7a &&
                  $urandom_range(0, 1) == 1)
                b = b ^ 8'h20;
              send_item(b, 1'b1, 1'b0);
            end
          end
        end
        5, 6, 7: send_item(pick_letter(), 1'b1, 1'b0);
        8:       send_item(8'($urandom_range(0, 255)), 1'b1, 1'b0);
        default: send_item(8'($urandom_range(0, 255)), 1'b0, 1'b0);
      endcase
    end
    if ($urandom_range(0, 5) == 0) send_item(8'($urandom_range(0, 255)), 1'b0, 1'b1);
    else                           send_item(8'($urandom_range(0, 255)), 1'b1, 1'b1);
  endtask

  // watchdog on cycles without any transaction
  initial begin
    quiet_cycles = 0;
    while (quiet_cycles < IdleLimit) begin
      @(posedge clk_i);
      if ((s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i) ||
          (cfg_valid_i && cfg_ready_o))
        quiet_cycles = 0;
      else
        quiet_cycles++;
    end
    $display("FAILURE");
    $finish;
  end

  initial begin
    int directed_items;
    rst_ni      = 1'b0;
    s_tvalid_i  = 1'b0;
    s_tdata_i   = 8'h00;
    s_tuser_i   = 1'b0;
    s_tlast_i   = 1'b0;
    m_tready_i  = 1'b0;
    cfg_valid_i = 1'b0;
    cfg_index_i = RegPattern;
    cfg_data_i  = '0;
    items_sent  = 0;
    burst_left  = 0;
    gappy       = 1'b1;
    ready_tick  = 0;
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // pass through: empty string, ignored item, byte extremes
    set_config('0, 4'd0, '0, 4'd0, 16'd1, 16'd0, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    send_item(8'hA5, 1'b0, 1'b0);
    send_item(8'h00, 1'b1, 1'b0);
    send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h5A, 1'b1, 1'b1);
    drain();

    // case-blind match, growing replacement, flush of a held byte
    set_config(64'h6261, 4'd2, 64'h5A5958, 4'd3, 16'd0, 16'd0, 1'b1);
    send_text("xaABabA", 1'b0);
    drain();

    // skipped overlapping occurrence, oversized replacement, limit of one
    set_config(64'h6161, 4'd2, '1, 4'd15, 16'd2, 16'd1, 1'b0);
    send_text("aaaaaa", 1'b0);
    drain();

    // full-width pattern deleted, then a bare end marker
    set_config('1, 4'd8, '0, 4'd0, 16'd0, 16'hFFFF, 1'b0);
    repeat (8) send_item(8'hFF, 1'b1, 1'b0);
    send_item(8'h00, 1'b0, 1'b1);
    drain();

    // random settings, a few strings each
    directed_items = items_sent;
    while (items_sent < directed_items + RandomItems) begin
      random_config();
      repeat ($urandom_range(2, 5)) send_random_string();
      drain();
    end

    wait (pending_results == 0);
    repeat (20) @(posedge clk_i);
    if (fail_count == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

endmodule
